[rtl/dtpf_pkg.sv]
package dtpf_pkg;

    localparam int DIG_W = 4;

    localparam logic CMD_DIGIT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [DIG_W-1:0] digit;
        logic             last;
    } req_t;

    typedef struct packed {
        logic conflict;
        logic list_ok;
        logic pool_full;
    } res_t;

endpackage

[rtl/dtpf_ram.sv]
module dtpf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/digit_trie_prefix_free_check_core.sv]
// Final digit to result strobe: with no walk, S_FIN and then the registered done; when a
// node is allocated, S_ALLOC first; when an existing child is followed, S_READ (child
// read) and S_ROW (row read) first. A new request is taken only in S_IDLE; a clear is
// done there without a strobe. The child-table then node-row read sets the pace.
// Reset (rst_n low, asynchronous) clears all control state and empties the trie at once;
// node rows are written on allocation and the root row lives in flip-flops, so no sweep.
module digit_trie_prefix_free_check_core
    import dtpf_pkg::*;
#(
    parameter int NODES = 4096,
    parameter int RADIX = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output res_t res
);

    localparam int AW    = $clog2(NODES);
    localparam int NFW   = AW + 1;
    localparam int SLOTS = NODES * RADIX;
    localparam int SW    = $clog2(SLOTS);
    localparam int RW    = RADIX + 1;
    localparam int DKW   = DIG_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_ROW   = 5'b00100,
        S_ALLOC = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    cursor_reg, cursor_next;
    logic [NFW-1:0]   next_free_reg, next_free_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RADIX-1:0] root_row_reg, root_row_next;
    logic             made_new_reg, made_new_next;
    logic             hit_end_reg, hit_end_next;
    logic             list_bad_reg, list_bad_next;
    logic             ran_out_reg, ran_out_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    res_t             res_reg, res_next;

    logic             child_we, child_re;
    logic [SW-1:0]    child_waddr, child_raddr, slot;
    logic [AW-1:0]    child_wdata, child_rdata;
    logic             node_we, node_re;
    logic [AW-1:0]    node_waddr, node_raddr;
    logic [RW-1:0]    node_wdata, node_rdata;

    logic [RADIX-1:0] dmask;
    logic             digit_ok, walk, slot_hit, conflict_c;

    dtpf_ram #(.DEPTH(SLOTS), .WIDTH(AW)) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    dtpf_ram #(.DEPTH(NODES), .WIDTH(RW)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign dmask    = {{(RADIX-1){1'b0}}, 1'b1} << req.digit;
    assign digit_ok = {1'b0, req.digit} < DKW'(RADIX);
    assign walk     = !list_bad_reg && !hit_end_reg && digit_ok;
    assign slot_hit = |(row_reg[RADIX-1:0] & dmask);
    assign slot     = SW'(cursor_reg) * SW'(RADIX) + SW'(req.digit);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        next_free_next = next_free_reg;
        row_next       = row_reg;
        root_row_next  = root_row_reg;
        made_new_next  = made_new_reg;
        hit_end_next   = hit_end_reg;
        list_bad_next  = list_bad_reg;
        ran_out_next   = ran_out_reg;
        last_next      = last_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        child_we       = 1'b0;
        child_waddr    = slot;
        child_wdata    = next_free_reg[AW-1:0];
        child_re       = 1'b0;
        child_raddr    = slot;
        node_we        = 1'b0;
        node_waddr     = cursor_reg;
        node_wdata     = row_reg | {1'b0, dmask};
        node_re        = 1'b0;
        node_raddr     = child_rdata;
        conflict_c     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = req.last;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        cursor_next    = '0;
                        next_free_next = NFW'(1);
                        row_next       = '0;
                        root_row_next  = '0;
                        made_new_next  = 1'b0;
                        hit_end_next   = 1'b0;
                        list_bad_next  = 1'b0;
                        ran_out_next   = 1'b0;
                    end
                    else if (walk && slot_hit)
                    begin
                        child_re   = 1'b1;
                        state_next = S_READ;
                    end
                    else if (walk && next_free_reg == NFW'(NODES))
                    begin
                        // pool exhausted: stop walking, mark the list bad
                        ran_out_next  = 1'b1;
                        list_bad_next = 1'b1;
                        state_next    = req.last ? S_FIN : S_IDLE;
                    end
                    else if (walk)
                    begin
                        child_we = 1'b1;
                        node_we  = 1'b1;
                        if (cursor_reg == '0)
                        begin
                            root_row_next = row_reg[RADIX-1:0] | dmask;
                        end
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = req.last ? S_FIN : S_IDLE;
                    end
                end
            end
            S_ALLOC:
            begin
                node_we        = 1'b1;
                node_waddr     = next_free_reg[AW-1:0];
                node_wdata     = '0;
                cursor_next    = next_free_reg[AW-1:0];
                next_free_next = next_free_reg + NFW'(1);
                made_new_next  = 1'b1;
                row_next       = '0;
                state_next     = last_reg ? S_FIN : S_IDLE;
            end
            S_READ:
            begin
                node_re     = 1'b1;
                cursor_next = child_rdata;
                state_next  = S_ROW;
            end
            S_ROW:
            begin
                row_next     = node_rdata;
                hit_end_next = node_rdata[RADIX];
                state_next   = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!ran_out_reg && !list_bad_reg)
                begin
                    conflict_c = hit_end_reg || !made_new_reg;
                    if (conflict_c)
                    begin
                        list_bad_next = 1'b1;
                    end
                    else
                    begin
                        node_we    = 1'b1;
                        node_wdata = row_reg | {1'b1, {RADIX{1'b0}}};
                    end
                end
                res_next.conflict  = conflict_c;
                res_next.list_ok   = !list_bad_next;
                res_next.pool_full = ran_out_reg;
                done_next          = 1'b1;
                cursor_next        = '0;
                row_next           = {1'b0, root_row_reg};
                made_new_next      = 1'b0;
                hit_end_next       = 1'b0;
                ran_out_next       = 1'b0;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            next_free_reg <= NFW'(1);
            row_reg       <= '0;
            root_row_reg  <= '0;
            made_new_reg  <= 1'b0;
            hit_end_reg   <= 1'b0;
            list_bad_reg  <= 1'b0;
            ran_out_reg   <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            next_free_reg <= next_free_next;
            row_reg       <= row_next;
            root_row_reg  <= root_row_next;
            made_new_reg  <= made_new_next;
            hit_end_reg   <= hit_end_next;
            list_bad_reg  <= list_bad_next;
            ran_out_reg   <= ran_out_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
            res_reg       <= res_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

[rtl/dtpf_checker.sv]
module dtpf_checker
    import dtpf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input res_t res
);

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_final_digit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_DIGIT && req.last) |=> busy)
        else $error("final digit accepted without result processing");

    a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_CLEAR) |=> (!busy && !done))
        else $error("clear request did not complete in one cycle");

    a_conflict_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.conflict) |-> !res.list_ok)
        else $error("conflict reported with list still ok");

    a_full_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.pool_full) |-> (!res.list_ok && !res.conflict))
        else $error("pool full reported with inconsistent flags");

endmodule

bind digit_trie_prefix_free_check_core dtpf_checker u_dtpf_checker (.*);
